@@ src/pdt_pkg.sv @@
// pdt_pkg: shared types, constants and helper functions of the joint pd torque unit
// no dependencies; imported by the interfaces and every module of the block
`timescale 1ns / 1ps

package pdt_pkg;

  localparam int POS_W    = 24;
  localparam int GAIN_W   = 20;
  localparam int FF_W     = 16;
  localparam int STEP_W   = 23;
  localparam int JOINT_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 23;

  // shared multiplier operand and product widths
  localparam int MUL_A_W  = 25;
  localparam int MUL_B_W  = 21;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_FACTOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TARGET_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TORQUE_STEP = 2'd2;

  localparam logic [FF_W-1:0]   FILTER_FACTOR_RST   = 16'd328;
  localparam logic [STEP_W-1:0] MAX_TARGET_STEP_RST = 23'd104858;
  localparam logic [STEP_W-1:0] MAX_TORQUE_STEP_RST = 23'd4096;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED,
    S_MULF,
    S_FT,
    S_MULP,
    S_MULD,
    S_RAW,
    S_RATE
  } step_t;

  typedef struct packed {
    logic  in_ready;
    step_t step;
  } ctrl_t;

  // clamp a signed value to +-lim, result fits 24 bits signed
  function automatic logic signed [23:0] clamp_lim(input logic signed [25:0] v,
                                                   input logic [STEP_W-1:0] lim);
    logic signed [25:0] hi;
    logic signed [25:0] lo;
    logic signed [25:0] r;
    hi = $signed({3'b000, lim});
    lo = -hi;
    if (v > hi) r = hi;
    else if (v < lo) r = lo;
    else r = v;
    return r[23:0];
  endfunction

  function automatic logic over_lim(input logic signed [25:0] v,
                                    input logic [STEP_W-1:0] lim);
    logic signed [25:0] hi;
    hi = $signed({3'b000, lim});
    return (v > hi) || (v < -hi);
  endfunction

  function automatic logic ovf24(input logic signed [31:0] v);
    return (v > 32'sd8388607) || (v < -32'sd8388608);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] r;
    if (v > 32'sd8388607) r = 24'sh7FFFFF;
    else if (v < -32'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

@@ src/pdt_in_if.sv @@
// pdt_in_if: input item channel of the joint pd torque unit (valid/ready plus fields)
// depends on pdt_pkg for field widths
`timescale 1ns / 1ps

interface pdt_in_if import pdt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [JOINT_W-1:0]       joint;
  logic signed [POS_W-1:0]  position;
  logic signed [POS_W-1:0]  velocity;
  logic signed [POS_W-1:0]  coriolis_torque;
  logic signed [POS_W-1:0]  target_position;
  logic [GAIN_W-1:0]        gain_p;
  logic [GAIN_W-1:0]        gain_d;

  modport source (output valid, action, joint, position, velocity, coriolis_torque,
                  target_position, gain_p, gain_d, input ready);
  modport sink   (input valid, action, joint, position, velocity, coriolis_torque,
                  target_position, gain_p, gain_d, output ready);
endinterface

@@ src/pdt_out_if.sv @@
// pdt_out_if: result item channel of the joint pd torque unit (valid/ready plus fields)
// depends on pdt_pkg for field widths
`timescale 1ns / 1ps

interface pdt_out_if import pdt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [JOINT_W-1:0]       joint_out;
  logic signed [POS_W-1:0]  torque;
  logic                     rate_limited;
  logic                     saturated;

  modport source (output valid, joint_out, torque, rate_limited, saturated, input ready);
  modport sink   (input valid, joint_out, torque, rate_limited, saturated, output ready);
endinterface

@@ src/pdt_mul.sv @@
// pdt_mul: shared signed multiplier with registered product
// depends on pdt_pkg for operand widths
`timescale 1ns / 1ps

module pdt_mul import pdt_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

@@ src/pdt_ctrl.sv @@
// pdt_ctrl: sequencer that steps one control sample through the shared multiplier
// depends on pdt_pkg for step_t and ctrl_t
`timescale 1ns / 1ps

module pdt_ctrl import pdt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  sample_ok,
  input  logic  out_free,
  output ctrl_t ctrl
);

  step_t step;
  step_t step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    step_next     = step;
    ctrl.in_ready = (step == S_IDLE);
    ctrl.step     = step;
    unique case (step)
      S_IDLE: begin
        if (in_valid && sample_ok) step_next = S_SEED;
      end
      S_SEED: step_next = S_MULF;
      S_MULF: step_next = S_FT;
      S_FT:   step_next = S_MULP;
      S_MULP: step_next = S_MULD;
      S_MULD: step_next = S_RAW;
      S_RAW:  step_next = S_RATE;
      S_RATE: begin
        if (out_free) step_next = S_IDLE;
      end
      default: step_next = S_IDLE;
    endcase
  end

endmodule

@@ src/joint_pd_torque_with_rate_limit_unit.sv @@
// Per-joint PD torque controller with target smoothing and torque rate limit. A control
// sample is loaded as a result from the rate-limit step, and the sequencer then returns
// to idle, where the next item can be accepted. One shared 25x21 multiplier
// is used three times in sequence (filter factor times target step, stiffness times
// position error, damping times velocity), each product registered, with seed, update,
// sum and rate-limit steps around it. A gain-load item and an item for a joint number at
// or above JOINTS are accepted and give no result. The result sits in an output
// register, so the next item is accepted while it waits; a new sample stalls in its last
// step only if the previous result has still not been taken.
// depends on pdt_pkg, pdt_in_if, pdt_out_if, pdt_mul, pdt_ctrl
`timescale 1ns / 1ps

module joint_pd_torque_with_rate_limit_unit import pdt_pkg::*; #(
  parameter int JOINTS = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  pdt_in_if.sink               in_item,
  pdt_out_if.source            out_item
);

  localparam int IDXW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  // configuration
  logic [FF_W-1:0]   filter_factor;
  logic [STEP_W-1:0] max_target_step;
  logic [STEP_W-1:0] max_torque_step;

  // per-joint state
  logic signed [POS_W-1:0]  ft_mem   [JOINTS];
  logic                     seeded   [JOINTS];
  logic signed [POS_W-1:0]  last_trq [JOINTS];
  logic [GAIN_W-1:0]        kp_mem   [JOINTS];
  logic [GAIN_W-1:0]        kd_mem   [JOINTS];

  // item registers
  logic [IDXW-1:0]          jidx;
  logic [JOINT_W-1:0]       joint_reg;
  logic signed [POS_W-1:0]  pos;
  logic signed [POS_W-1:0]  vel;
  logic signed [POS_W-1:0]  cor;
  logic signed [POS_W-1:0]  tgt;

  // working registers
  logic signed [POS_W-1:0]   ft_cur;
  logic signed [POS_W-1:0]   d_reg;
  logic signed [MUL_P_W-1:0] acc;
  logic signed [POS_W-1:0]   raw_reg;
  logic                      sat_reg;

  // output register
  logic                     out_valid;
  logic [JOINT_W-1:0]       out_joint;
  logic signed [POS_W-1:0]  out_torque;
  logic                     out_limited;
  logic                     out_sat;

  ctrl_t ctrl;
  logic  in_fire;
  logic  joint_ok;
  logic  sample_ok;
  logic  out_free;
  logic [IDXW+JOINT_W-1:0] joint_ext;
  logic [IDXW-1:0]         in_idx;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  logic signed [POS_W-1:0]   ft0;
  logic signed [25:0]        tdiff;
  logic signed [MUL_P_W-1:0] f_sum;
  logic signed [31:0]        ft_sum;
  logic signed [POS_W-1:0]   ft_new;
  logic signed [MUL_P_W:0]   pd;
  logic signed [MUL_P_W:0]   pd_r;
  logic signed [31:0]        raw_sum;
  logic signed [25:0]        qdiff;
  logic signed [POS_W-1:0]   c_step;
  logic signed [POS_W-1:0]   tq;

  assign joint_ext = {{IDXW{1'b0}}, in_item.joint};
  assign in_idx    = joint_ext[IDXW-1:0];
  assign joint_ok  = {2'b00, in_item.joint} < 5'(JOINTS);
  assign sample_ok = joint_ok && (in_item.action == ACT_SAMPLE);
  assign out_free  = !out_valid || out_item.ready;
  assign in_fire   = in_item.valid && ctrl.in_ready;

  assign in_item.ready = ctrl.in_ready;

  pdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_item.valid),
    .sample_ok (sample_ok),
    .out_free  (out_free),
    .ctrl      (ctrl)
  );

  pdt_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.step)
      S_MULF: begin
        mul_a = {d_reg[POS_W-1], d_reg};
        mul_b = {5'b00000, filter_factor};
      end
      S_MULP: begin
        mul_a = $signed({ft_cur[POS_W-1], ft_cur}) - $signed({pos[POS_W-1], pos});
        mul_b = {1'b0, kp_mem[jidx]};
      end
      S_MULD: begin
        mul_a = {vel[POS_W-1], vel};
        mul_b = {1'b0, kd_mem[jidx]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // datapath arithmetic
  always_comb begin
    ft0    = seeded[jidx] ? ft_mem[jidx] : pos;
    tdiff  = $signed({{2{tgt[POS_W-1]}}, tgt}) - $signed({{2{ft0[POS_W-1]}}, ft0});
    // round to nearest, ties up: add half then floor shift
    f_sum  = prod + MUL_P_W'(32768);
    ft_sum = $signed({{8{ft_cur[POS_W-1]}}, ft_cur})
           + $signed({{7{f_sum[40]}}, f_sum[40:16]});
    ft_new = sat24(ft_sum);
    pd     = $signed({acc[MUL_P_W-1], acc}) - $signed({prod[MUL_P_W-1], prod});
    pd_r   = pd + (MUL_P_W+1)'(32768);
    raw_sum = $signed({pd_r[MUL_P_W], pd_r[46:16]}) + $signed({{8{cor[POS_W-1]}}, cor});
    qdiff  = $signed({{2{raw_reg[POS_W-1]}}, raw_reg})
           - $signed({{2{last_trq[jidx][POS_W-1]}}, last_trq[jidx]});
    c_step = clamp_lim(qdiff, max_torque_step);
    tq     = sat24($signed({{8{last_trq[jidx][POS_W-1]}}, last_trq[jidx]})
                   + $signed({{8{c_step[POS_W-1]}}, c_step}));
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_factor   <= FILTER_FACTOR_RST;
      max_target_step <= MAX_TARGET_STEP_RST;
      max_torque_step <= MAX_TORQUE_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILTER_FACTOR:   filter_factor   <= cfg_data[FF_W-1:0];
        CFG_MAX_TARGET_STEP: max_target_step <= cfg_data[STEP_W-1:0];
        CFG_MAX_TORQUE_STEP: max_torque_step <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // per-joint state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOINTS; i++) begin
        ft_mem[i]   <= '0;
        seeded[i]   <= 1'b0;
        last_trq[i] <= '0;
        kp_mem[i]   <= '0;
        kd_mem[i]   <= '0;
      end
    end else begin
      if (in_fire && joint_ok && (in_item.action == ACT_LOAD)) begin
        kp_mem[in_idx] <= in_item.gain_p;
        kd_mem[in_idx] <= in_item.gain_d;
      end
      if (ctrl.step == S_FT) begin
        ft_mem[jidx] <= ft_new;
        seeded[jidx] <= 1'b1;
      end
      if ((ctrl.step == S_RATE) && out_free) begin
        last_trq[jidx] <= tq;
      end
    end
  end

  // item and working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      jidx      <= in_idx;
      joint_reg <= in_item.joint;
      pos       <= in_item.position;
      vel       <= in_item.velocity;
      cor       <= in_item.coriolis_torque;
      tgt       <= in_item.target_position;
    end
    unique case (ctrl.step)
      S_SEED: begin
        ft_cur <= ft0;
        d_reg  <= clamp_lim(tdiff, max_target_step);
      end
      S_FT:   ft_cur <= ft_new;
      S_MULD: acc <= prod;
      S_RAW: begin
        raw_reg <= sat24(raw_sum);
        sat_reg <= ovf24(raw_sum);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((ctrl.step == S_RATE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.step == S_RATE) && out_free) begin
      out_joint   <= joint_reg;
      out_torque  <= tq;
      out_limited <= over_lim(qdiff, max_torque_step);
      out_sat     <= sat_reg;
    end
  end

  assign out_item.valid        = out_valid;
  assign out_item.joint_out    = out_joint;
  assign out_item.torque       = out_torque;
  assign out_item.rate_limited = out_limited;
  assign out_item.saturated    = out_sat;

  // a result is only loaded from the rate-limit step
  a_load_from_rate: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.step == S_RATE))
    else $error("result loaded outside rate-limit step");

  // a waiting result is never overwritten by the next sample
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.ready && (ctrl.step == S_RATE)) |=> (ctrl.step == S_RATE))
    else $error("sequencer left rate-limit step while result was stalled");

  // the filtered-target update always marks the joint seeded
  a_seeded_after_update: assert property (@(posedge clk) disable iff (rst)
    (ctrl.step == S_FT) |=> seeded[jidx])
    else $error("joint not seeded after filtered-target update");

endmodule
